// ===== rtl/dnsrp_pkg.sv =====
// dnsrp_pkg: types, codes and constants shared by the DNS reply parser.
// No dependencies; compiled first.
package dnsrp_pkg;

  localparam int DNSRP_MAX_PACKET  = 1036;
  localparam int DNSRP_MAX_ANSWERS = 16;

  localparam logic [7:0]  QR_MASK      = 8'h80;
  localparam logic [7:0]  OPCODE_MASK  = 8'h78;
  localparam logic [7:0]  RCODE_MASK   = 8'h0F;
  localparam logic [7:0]  LABEL_MAX    = 8'd63;
  localparam logic [15:0] RDLEN_MAX    = 16'd1023;
  localparam int          HEADER_LEN   = 12;
  localparam logic [15:0] FIXED_LEN    = 16'd10;
  localparam logic [15:0] Q_PTR_TAIL   = 16'd5;
  localparam logic [15:0] Q_ROOT_TAIL  = 16'd4;
  localparam logic [15:0] RR_TYPE_A    = 16'd1;
  localparam logic [15:0] RR_CLASS_IN  = 16'd1;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_ID        = 4'd1;
  localparam logic [3:0] ST_NOT_RESP  = 4'd2;
  localparam logic [3:0] ST_OPCODE    = 4'd3;
  localparam logic [3:0] ST_RCODE     = 4'd4;
  localparam logic [3:0] ST_NO_ANSWER = 4'd5;
  localparam logic [3:0] ST_Q_LEN     = 4'd6;
  localparam logic [3:0] ST_A_LEN     = 4'd7;
  localparam logic [3:0] ST_RR_LEN    = 4'd8;

  localparam logic KIND_RDATA  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [10:0] {
    SEC_HEADER  = 11'b000_0000_0001,
    SEC_Q_NAME  = 11'b000_0000_0010,
    SEC_Q_SKIP  = 11'b000_0000_0100,
    SEC_A_NAME  = 11'b000_0000_1000,
    SEC_A_LABEL = 11'b000_0001_0000,
    SEC_A_PTR   = 11'b000_0010_0000,
    SEC_A_FIXED = 11'b000_0100_0000,
    SEC_A_SKIP  = 11'b000_1000_0000,
    SEC_A_EMIT  = 11'b001_0000_0000,
    SEC_A_LONG  = 11'b010_0000_0000,
    SEC_DONE    = 11'b100_0000_0000
  } sec_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] data_byte;
    logic [3:0] record_index;
    logic       record_end;
    logic [3:0] status_code;
    logic [3:0] rcode_value;
    logic [4:0] answer_count;
    logic       last;
  } res_t;

  // rdata item in slot 0, status item in slot 1
  typedef struct packed {
    logic v0;
    res_t r0;
    logic v1;
    res_t r1;
  } res_pair_t;

endpackage

// ===== rtl/dnsrp_if.sv =====
// Handshake interfaces of the DNS reply parser: byte input, result output, config write.
// Depends on dnsrp_pkg.
interface dnsrp_byte_if import dnsrp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_packet;
  modport source (output valid, byte_value, end_of_packet, input ready);
  modport sink   (input valid, byte_value, end_of_packet, output ready);
endinterface

interface dnsrp_res_if import dnsrp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] data_byte;
  logic [3:0] record_index;
  logic       record_end;
  logic [3:0] status_code;
  logic [3:0] rcode_value;
  logic [4:0] answer_count;
  logic       last;
  modport source (output valid, item_kind, data_byte, record_index, record_end,
                  status_code, rcode_value, answer_count, last, input ready);
  modport sink   (input valid, item_kind, data_byte, record_index, record_end,
                  status_code, rcode_value, answer_count, last, output ready);
endinterface

interface dnsrp_cfg_if import dnsrp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [15:0] expected_id;
  modport source (output valid, expected_id, input ready);
  modport sink   (input valid, expected_id, output ready);
endinterface

// ===== rtl/dnsrp_parse.sv =====
// dnsrp_parse: per-byte section state machine of the DNS reply parser.
// Depends on dnsrp_pkg. Emits up to two results per accepted byte.
module dnsrp_parse import dnsrp_pkg::*; #(
  parameter int MAX_PACKET  = DNSRP_MAX_PACKET,
  parameter int MAX_ANSWERS = DNSRP_MAX_ANSWERS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  byte_value,
  input  logic        end_of_packet,
  input  logic [15:0] expected_id,
  output res_pair_t   res_pair
);

  localparam int PosW = $clog2(MAX_PACKET + 1);
  localparam int CntW = $clog2(MAX_ANSWERS + 1);

  sec_t            sec, sec_next;
  logic [PosW-1:0] pos, pos_next;
  logic [15:0]     skip, skip_next;
  logic [15:0]     qleft, qleft_next;
  logic [15:0]     aleft, aleft_next;
  logic [CntW-1:0] acnt, acnt_next;
  logic [3:0]      err, err_next;
  logic [7:0]      hdr [8];
  logic [15:0]     rr_type, rr_class;
  logic [7:0]      rdlen_hi;

  logic            in_range;
  logic [15:0]     skip_dec, fin_aleft, rdlen, hdr_id, hdr_ancount;
  logic            below_max;
  logic [3:0]      st;

  assign in_range    = pos < PosW'(MAX_PACKET);
  assign skip_dec    = skip - 16'd1;
  assign fin_aleft   = aleft - 16'd1;
  assign rdlen       = {rdlen_hi, byte_value};
  assign hdr_id      = {hdr[0], hdr[1]};
  assign hdr_ancount = {hdr[6], hdr[7]};
  assign below_max   = acnt < CntW'(MAX_ANSWERS);

  always_comb begin
    sec_next   = sec;
    pos_next   = pos;
    skip_next  = skip;
    qleft_next = qleft;
    aleft_next = aleft;
    acnt_next  = acnt;
    err_next   = err;
    res_pair   = '0;

    if (in_range) begin
      pos_next = pos + PosW'(1);
      unique case (sec)
        SEC_HEADER: begin
          if (pos == PosW'(HEADER_LEN - 1)) begin
            priority if (hdr_id != expected_id) begin
              err_next = ST_ID;        sec_next = SEC_DONE;
            end else if ((hdr[2] & QR_MASK) == 8'd0) begin
              err_next = ST_NOT_RESP;  sec_next = SEC_DONE;
            end else if ((hdr[2] & OPCODE_MASK) != 8'd0) begin
              err_next = ST_OPCODE;    sec_next = SEC_DONE;
            end else if ((hdr[3] & RCODE_MASK) != 8'd0) begin
              err_next = ST_RCODE;     sec_next = SEC_DONE;
            end else if (hdr_ancount == 16'd0) begin
              err_next = ST_NO_ANSWER; sec_next = SEC_DONE;
            end else begin
              qleft_next = {hdr[4], hdr[5]};
              aleft_next = hdr_ancount;
              sec_next   = ({hdr[4], hdr[5]} != 16'd0) ? SEC_Q_NAME : SEC_A_NAME;
            end
          end
        end
        SEC_Q_NAME: begin
          priority if (byte_value > LABEL_MAX) begin
            skip_next  = Q_PTR_TAIL;
            qleft_next = qleft - 16'd1;
          end else if (byte_value == 8'd0) begin
            skip_next  = Q_ROOT_TAIL;
            qleft_next = qleft - 16'd1;
          end else begin
            skip_next = {8'd0, byte_value};
          end
          sec_next = SEC_Q_SKIP;
        end
        SEC_Q_SKIP: begin
          skip_next = skip_dec;
          if (skip_dec == 16'd0) sec_next = (qleft != 16'd0) ? SEC_Q_NAME : SEC_A_NAME;
        end
        SEC_A_NAME: begin
          priority if (byte_value > LABEL_MAX) begin
            sec_next = SEC_A_PTR;
          end else if (byte_value == 8'd0) begin
            skip_next = FIXED_LEN;
            sec_next  = SEC_A_FIXED;
          end else begin
            skip_next = {8'd0, byte_value};
            sec_next  = SEC_A_LABEL;
          end
        end
        SEC_A_LABEL: begin
          skip_next = skip_dec;
          if (skip_dec == 16'd0) sec_next = SEC_A_NAME;
        end
        SEC_A_PTR: begin
          skip_next = FIXED_LEN;
          sec_next  = SEC_A_FIXED;
        end
        SEC_A_FIXED: begin
          skip_next = skip_dec;
          if (skip_dec == 16'd0) begin
            skip_next = rdlen;
            priority if (rr_class != RR_CLASS_IN || rr_type != RR_TYPE_A) begin
              if (rdlen == 16'd0) begin
                aleft_next = fin_aleft;
                sec_next   = (fin_aleft == 16'd0) ? SEC_DONE : SEC_A_NAME;
              end else begin
                sec_next = SEC_A_SKIP;
              end
            end else if (rdlen > RDLEN_MAX) begin
              sec_next = SEC_A_LONG;
            end else if (rdlen == 16'd0) begin
              if (below_max) acnt_next = acnt + CntW'(1);
              aleft_next = fin_aleft;
              sec_next   = (fin_aleft == 16'd0) ? SEC_DONE : SEC_A_NAME;
            end else begin
              sec_next = SEC_A_EMIT;
            end
          end
        end
        SEC_A_SKIP: begin
          skip_next = skip_dec;
          if (skip_dec == 16'd0) begin
            aleft_next = fin_aleft;
            sec_next   = (fin_aleft == 16'd0) ? SEC_DONE : SEC_A_NAME;
          end
        end
        SEC_A_EMIT: begin
          skip_next = skip_dec;
          if (below_max) begin
            res_pair.v0              = accept;
            res_pair.r0.item_kind    = KIND_RDATA;
            res_pair.r0.data_byte    = byte_value;
            res_pair.r0.record_index = 4'(acnt);
            res_pair.r0.record_end   = (skip_dec == 16'd0);
          end
          if (skip_dec == 16'd0) begin
            if (below_max) acnt_next = acnt + CntW'(1);
            aleft_next = fin_aleft;
            sec_next   = (fin_aleft == 16'd0) ? SEC_DONE : SEC_A_NAME;
          end
        end
        SEC_A_LONG: begin
          skip_next = skip_dec;
          if (skip_dec == 16'd0) begin
            err_next = ST_RR_LEN;
            sec_next = SEC_DONE;
          end
        end
        SEC_DONE: begin
        end
        default: begin
        end
      endcase
    end

    unique case (sec_next)
      SEC_HEADER:  st = ST_OK;
      SEC_Q_NAME:  st = ST_Q_LEN;
      SEC_Q_SKIP:  st = (qleft_next != 16'd0) ? ST_Q_LEN : ST_A_LEN;
      SEC_A_NAME, SEC_A_LABEL, SEC_A_PTR, SEC_A_FIXED: st = ST_A_LEN;
      SEC_A_SKIP:  st = (aleft_next > 16'd1) ? ST_A_LEN : ST_OK;
      SEC_A_EMIT, SEC_A_LONG: st = ST_OK;
      default:     st = err_next;
    endcase

    if (end_of_packet) begin
      res_pair.v1              = accept;
      res_pair.r1.item_kind    = KIND_STATUS;
      res_pair.r1.status_code  = st;
      res_pair.r1.rcode_value  = (st == ST_RCODE) ? hdr[3][3:0] : 4'd0;
      res_pair.r1.answer_count = 5'(acnt_next);
      res_pair.r1.last         = 1'b1;
      sec_next   = SEC_HEADER;
      pos_next   = '0;
      skip_next  = '0;
      qleft_next = '0;
      aleft_next = '0;
      acnt_next  = '0;
      err_next   = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sec   <= SEC_HEADER;
      pos   <= '0;
      skip  <= '0;
      qleft <= '0;
      aleft <= '0;
      acnt  <= '0;
      err   <= ST_OK;
    end else if (accept) begin
      sec   <= sec_next;
      pos   <= pos_next;
      skip  <= skip_next;
      qleft <= qleft_next;
      aleft <= aleft_next;
      acnt  <= acnt_next;
      err   <= err_next;
    end
  end

  // header and fixed-field capture; always written before being read
  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      if (sec == SEC_HEADER && pos < PosW'(8)) hdr[pos[2:0]] <= byte_value;
      if (sec == SEC_A_FIXED) begin
        unique case (skip)
          16'd10:  rr_type[15:8]  <= byte_value;
          16'd9:   rr_type[7:0]   <= byte_value;
          16'd8:   rr_class[15:8] <= byte_value;
          16'd7:   rr_class[7:0]  <= byte_value;
          16'd2:   rdlen_hi       <= byte_value;
          default: begin
          end
        endcase
      end
    end
  end

  a_eop_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_packet) |=> (sec == SEC_HEADER && pos == '0 && acnt == '0))
    else $error("state not cleared after end of packet");

  a_rdata_src: assert property (@(posedge clk) disable iff (rst)
    res_pair.v0 |-> (sec == SEC_A_EMIT && below_max && in_range))
    else $error("rdata item outside an accepted A record");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    acnt <= CntW'(MAX_ANSWERS))
    else $error("record count beyond limit");

endmodule

// ===== rtl/dnsrp_out_fifo.sv =====
// dnsrp_out_fifo: four-entry result queue; up to two in per cycle, one out on out_ready.
// Depends on dnsrp_pkg.
module dnsrp_out_fifo import dnsrp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  res_pair_t push,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output res_t      out_item
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  res_t            mem [Depth];
  logic [PtrW-1:0] wptr, rptr;
  logic [CntW-1:0] count, count_next;
  logic            pop;
  logic [1:0]      n_push;

  assign space     = count <= CntW'(Depth - 2);
  assign out_valid = count != '0;
  assign out_item  = mem[rptr];
  assign pop       = out_valid && out_ready;
  assign n_push    = 2'(push.v0) + 2'(push.v1);
  assign count_next = count + CntW'(n_push) - CntW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PtrW'(n_push);
      rptr  <= rptr + PtrW'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) mem[wptr] <= push.r0;
    if (push.v1) mem[push.v0 ? wptr + PtrW'(1) : wptr] <= push.r1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (n_push == 2'd2 && !pop) |=> count == $past(count) + CntW'(2))
    else $error("result queue count lost a push");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (n_push != 2'd0) |-> (count <= CntW'(Depth - 2)))
    else $error("push into full result queue");

endmodule

// ===== rtl/dns_response_parser.sv =====
// dns_response_parser: top level; DNS reply byte parser that streams IN/A rdata.
// Depends on dnsrp_pkg, dnsrp_if, dnsrp_parse, dnsrp_out_fifo.
//
//  channel | dir | handshake     | payload
//  pkt     | in  | valid/ready   | byte_value[7:0], end_of_packet
//  res     | out | valid/ready   | item_kind, data_byte, record_index, record_end,
//          |     |               | status_code, rcode_value, answer_count, last
//  cfg     | in  | valid/ready   | expected_id[15:0], ready high out of reset
//
// One byte accepted per cycle while pkt.ready is high; its results enter a 4-entry
// queue the same cycle. pkt.ready drops while the queue holds more than two items.
// rst (sync) clears parser state and the queue, and sets expected_id to 0;
// pkt.ready and cfg.ready stay low while rst is high. A stalled res side holds
// the queue head.
module dns_response_parser import dnsrp_pkg::*; #(
  parameter int MAX_PACKET  = DNSRP_MAX_PACKET,
  parameter int MAX_ANSWERS = DNSRP_MAX_ANSWERS
) (
  input logic         clk,
  input logic         rst,
  dnsrp_byte_if.sink  pkt,
  dnsrp_res_if.source res,
  dnsrp_cfg_if.sink   cfg
);

  logic [15:0] expected_id;
  logic        space;
  logic        accept;
  res_pair_t   res_pair;
  res_t        head;

  assign cfg.ready = !rst;
  assign pkt.ready = space && !rst;
  assign accept    = pkt.valid && space && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= '0;
    end else if (cfg.valid) begin
      expected_id <= cfg.expected_id;
    end
  end

  dnsrp_parse #(
    .MAX_PACKET  (MAX_PACKET),
    .MAX_ANSWERS (MAX_ANSWERS)
  ) u_parse (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .byte_value    (pkt.byte_value),
    .end_of_packet (pkt.end_of_packet),
    .expected_id   (expected_id),
    .res_pair      (res_pair)
  );

  dnsrp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_pair),
    .space     (space),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_item  (head)
  );

  assign res.item_kind    = head.item_kind;
  assign res.data_byte    = head.data_byte;
  assign res.record_index = head.record_index;
  assign res.record_end   = head.record_end;
  assign res.status_code  = head.status_code;
  assign res.rcode_value  = head.rcode_value;
  assign res.answer_count = head.answer_count;
  assign res.last         = head.last;

endmodule
